// ===== design/multichannel_pwm_pulse_capture_defines.svh =====
// ----------------------------------------------------------------------------
// multichannel_pwm_pulse_capture assertion macros
// Concurrent assertion wrappers clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_PWM_PULSE_CAPTURE_DEFINES_SVH
`define MULTICHANNEL_PWM_PULSE_CAPTURE_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== design/mpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// mpwm_pkg
// Shared types and constants of the PWM pulse capture block.
// ----------------------------------------------------------------------------
package mpwm_pkg;

	localparam int CHANNELS_DEF = 6;
	localparam int MAX_CHANNELS = 8;
	localparam int PIN_COUNT    = 6;
	localparam int CH_W         = 3;
	localparam int TIME_W       = 32;
	localparam int WIDTH_W      = 16;
	localparam int IN_DATA_W    = 48;
	localparam int OUT_DATA_W   = 24;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 32;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [WIDTH_W-1:0] MIN_WIDTH_RST = 16'd900;
	localparam logic [WIDTH_W-1:0] MAX_WIDTH_RST = 16'd2100;
	localparam logic [TIME_W-1:0]  TIMEOUT_RST   = 32'd100000;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_READ   = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_WIDTH = 2'd0,
		REG_MAX_WIDTH = 2'd1,
		REG_TIMEOUT   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		op_t                   op;
		logic [PIN_COUNT-1:0]  pins;
		logic [PIN_COUNT-1:0]  changed;
		logic [TIME_W-1:0]     time_us;
		logic [CH_W-1:0]       ch;
	} mpwm_entry_t;

endpackage

// ===== design/multichannel_pwm_pulse_capture.sv =====
// An input word is written into the 2-entry queue, then into the output register when popped.
// Throughput: one word per cycle while neither side stalls; the back stage's channel update
// and the 2-entry queue let input and output stall independently.
// Reset: config registers return to 900/2100/100000 us, pin history, rise and
// update flags and stored widths clear at once; no clearing pass.
// ----------------------------------------------------------------------------
// multichannel_pwm_pulse_capture
// Multichannel RC PWM pulse width capture with channel read-back.
// ----------------------------------------------------------------------------
module multichannel_pwm_pulse_capture
	import mpwm_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
)
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // pin_levels, time_us, channel_index
	input  logic                  s_tuser,  // operation
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // pulse_width_us, alive, updated_mask
);

	logic        q_push;
	logic        q_full;
	logic        q_valid;
	logic        q_pop;
	mpwm_entry_t wr_entry;
	mpwm_entry_t rd_entry;

	mpwm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (wr_entry)
	);

	mpwm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (wr_entry),
		.full     (q_full),
		.valid    (q_valid),
		.rd_entry (rd_entry),
		.pop      (q_pop)
	);

	mpwm_back #(
		.CHANNELS (CHANNELS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_entry   (rd_entry),
		.q_pop     (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// ===== design/mpwm_front.sv =====
// ----------------------------------------------------------------------------
// mpwm_front
// Accepts input words, tracks pin levels and flags changed pins.
// ----------------------------------------------------------------------------
module mpwm_front
	import mpwm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,  // pin_levels, time_us, channel_index
	input  logic                 s_tuser,  // operation
	input  logic                 q_full,
	output logic                 q_push,
	output mpwm_entry_t          q_entry
);

	logic [PIN_COUNT-1:0] prev_levels_q;
	logic [PIN_COUNT-1:0] pins;

	assign pins     = s_tdata[PIN_COUNT-1:0];
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && s_tready;

	always_comb begin
		q_entry.op      = op_t'(s_tuser);
		q_entry.pins    = pins;
		q_entry.changed = (q_entry.op == OP_SAMPLE) ? (pins ^ prev_levels_q) : '0;
		q_entry.time_us = s_tdata[PIN_COUNT +: TIME_W];
		q_entry.ch      = s_tdata[PIN_COUNT+TIME_W +: CH_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_levels_q <= '0;
		end else if (q_push && q_entry.op == OP_SAMPLE) begin
			prev_levels_q <= pins;
		end
	end

endmodule

// ===== design/mpwm_queue.sv =====
// ----------------------------------------------------------------------------
// mpwm_queue
// Short FIFO of classified words between front and back.
// ----------------------------------------------------------------------------
module mpwm_queue
	import mpwm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  mpwm_entry_t wr_entry,
	output logic        full,
	output logic        valid,
	output mpwm_entry_t rd_entry,
	input  logic        pop
);

	localparam int AW = $clog2(QUEUE_DEPTH);

	mpwm_entry_t     mem_q [QUEUE_DEPTH];
	logic [AW-1:0]   wptr_q;
	logic [AW-1:0]   rptr_q;
	logic [AW:0]     count_q;

	assign full     = (count_q == (AW+1)'(QUEUE_DEPTH));
	assign valid    = (count_q != '0);
	assign rd_entry = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/mpwm_back.sv =====
// ----------------------------------------------------------------------------
// mpwm_back
// Channel state, width capture, channel reads and the output register.
// ----------------------------------------------------------------------------
`include "multichannel_pwm_pulse_capture_defines.svh"

module mpwm_back
	import mpwm_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
)
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  q_valid,
	input  mpwm_entry_t           q_entry,
	output logic                  q_pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata  // pulse_width_us, alive, updated_mask
);

	localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [WIDTH_W-1:0] min_q;
	logic [WIDTH_W-1:0] max_q;
	logic [TIME_W-1:0]  timeout_q;

	logic [WIDTH_W-1:0] rise_time_q    [CHANNELS];
	logic [WIDTH_W-1:0] stored_width_q [CHANNELS];
	logic [TIME_W-1:0]  update_time_q  [CHANNELS];
	logic [CHANNELS-1:0] rise_seen_q;
	logic [CHANNELS-1:0] update_seen_q;

	logic                 m_valid_q;
	logic [WIDTH_W-1:0]   width_out_q;
	logic                 alive_out_q;
	logic [PIN_COUNT-1:0] mask_out_q;

	logic [MAX_CHANNELS-1:0] pins_ext;
	logic [MAX_CHANNELS-1:0] chg_ext;
	logic [MAX_CHANNELS-1:0] upd_ext;
	logic [MAX_CHANNELS-1:0] seen_ext;
	logic [CHANNELS-1:0]     rise_d;
	logic [CHANNELS-1:0]     upd_d;
	logic [WIDTH_W-1:0]      pulse_w [CHANNELS];
	logic                    is_sample;
	logic                    ch_in_range;
	logic [IW-1:0]           idx;
	logic [TIME_W-1:0]       age;
	logic [WIDTH_W-1:0]      rd_width;
	logic                    alive_d;

	assign cfg_ready = 1'b1;
	assign q_pop     = q_valid && (!m_valid_q || m_tready);
	assign is_sample = (q_entry.op == OP_SAMPLE);
	assign pins_ext  = MAX_CHANNELS'(q_entry.pins);
	assign chg_ext   = MAX_CHANNELS'(q_entry.changed);

	always_comb begin
		upd_ext  = '0;
		seen_ext = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			pulse_w[i] = q_entry.time_us[WIDTH_W-1:0] - rise_time_q[i];
			rise_d[i]  = is_sample && chg_ext[i] && pins_ext[i];
			upd_d[i]   = is_sample && chg_ext[i] && !pins_ext[i] && rise_seen_q[i]
				&& (pulse_w[i] >= min_q) && (pulse_w[i] <= max_q);
			upd_ext[i]  = upd_d[i];
			seen_ext[i] = update_seen_q[i];
		end
	end

	assign ch_in_range = ({1'b0, q_entry.ch} < (CH_W+1)'(CHANNELS));
	assign idx         = q_entry.ch[IW-1:0];
	assign age         = q_entry.time_us - update_time_q[idx];
	assign rd_width    = ch_in_range ? stored_width_q[idx] : '0;
	assign alive_d     = !is_sample && ch_in_range && update_seen_q[idx] && (age < timeout_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q     <= MIN_WIDTH_RST;
			max_q     <= MAX_WIDTH_RST;
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MIN_WIDTH: min_q     <= cfg_data[WIDTH_W-1:0];
				REG_MAX_WIDTH: max_q     <= cfg_data[WIDTH_W-1:0];
				REG_TIMEOUT:   timeout_q <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_seen_q   <= '0;
			update_seen_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				stored_width_q[i] <= '0;
			end
		end else if (q_pop) begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (rise_d[i]) begin
					rise_seen_q[i] <= 1'b1;
				end
				if (upd_d[i]) begin
					update_seen_q[i]  <= 1'b1;
					stored_width_q[i] <= pulse_w[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (rise_d[i]) begin
					rise_time_q[i] <= q_entry.time_us[WIDTH_W-1:0];
				end
				if (upd_d[i]) begin
					update_time_q[i] <= q_entry.time_us;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (q_pop) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			width_out_q <= is_sample ? '0 : rd_width;
			alive_out_q <= alive_d;
			mask_out_q  <= is_sample ? upd_ext[PIN_COUNT-1:0] : '0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, mask_out_q, alive_out_q, width_out_q};

	// reported channels must be marked updated
	`ASSERT_NEXT(a_mask_seen, q_pop && is_sample, (mask_out_q & ~seen_ext[PIN_COUNT-1:0]) == '0)
	`ASSERT_NEXT(a_read_no_mask, q_pop && !is_sample, mask_out_q == '0)
	`ASSERT_IMPL(a_alive_range, alive_d, ch_in_range && !is_sample)

endmodule
